// ===== design/sorted_departure_table_top_assert.svh =====
// Assertion macros for the sorted departure table.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef SORTED_DEPARTURE_TABLE_TOP_ASSERT_SVH
`define SORTED_DEPARTURE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SDT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SDT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sdt_pkg.sv =====
// Shared types, sizes and codes for the sorted departure table.
// No dependencies.
`timescale 1ns / 1ps

package sdt_pkg;

  // Table geometry
  localparam int PLATFORMS = 8;
  localparam int ENTRIES   = 16;

  localparam int PLAT_W  = 3;
  localparam int TIME_W  = 12;
  localparam int TRAIN_W = 16;

  localparam int PIDX_W = (PLATFORMS > 1) ? $clog2(PLATFORMS) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int DEPTH  = PLATFORMS * ENTRIES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Time code for "no departure"; also the first invalid time
  localparam logic [TIME_W-1:0] TIME_NONE = TIME_W'(2400);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_PLAT  = 2'd2,
    ST_BAD_TIME  = 2'd3
  } status_e;

  // One slot of a platform table
  typedef struct packed {
    logic [TIME_W-1:0]  tod;
    logic [TRAIN_W-1:0] train;
  } slot_t;

  // Flat slot address of entry idx on platform plat
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [PIDX_W-1:0] plat,
                                                  input logic [CNT_W-1:0]  idx);
    slot_addr = ADDR_W'(int'(plat) * ENTRIES + int'(idx));
  endfunction

endpackage

// ===== design/sdt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module sdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sorted_departure_table_top.sv =====
// Sorted departure table: per-platform time-ordered slots in one RAM, with a
// scan/shift sequencer. Depends on sdt_pkg, sdt_ram and the assertion header.
//
// A request is taken when start is high and busy is low; its result shows on
// the result ports for one cycle with done_o and cannot be held off. Error
// requests and queries on an empty platform raise no busy: the result follows
// in the next cycle. A query scans the platform's slots upward from slot 0
// until it meets a departure later than the requested time or its entries run
// out; an insert shifts the later entries up one slot each, from the top
// down, then writes the new entry into the gap. The result appears in the
// first cycle with busy low, and a new request may be taken in that same
// cycle. The slot RAM's single read port feeds the scan one slot per cycle.
`timescale 1ns / 1ps
`include "sorted_departure_table_top_assert.svh"

module sorted_departure_table_top
  import sdt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  input  logic               cmd_i,
  input  logic [PLAT_W-1:0]  platform_i,
  input  logic [TIME_W-1:0]  time_of_day_i,
  input  logic [TRAIN_W-1:0] train_number_i,
  output logic [1:0]         status_o,
  output logic               found_o,
  output logic [TRAIN_W-1:0] next_train_o,
  output logic [TIME_W-1:0]  next_time_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_QSCAN,
    S_ISCAN
  } state_e;

  state_e               state_q, state_d;
  logic [PIDX_W-1:0]    plat_q, plat_d;
  logic [TIME_W-1:0]    time_q, time_d;
  logic [TRAIN_W-1:0]   train_q, train_d;
  logic [CNT_W-1:0]     pos_q, pos_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     cnt_mem_q [PLATFORMS];
  logic                 cnt_we;

  logic                 done_q, done_d;
  status_e              status_q, status_d;
  logic                 found_q, found_d;
  logic [TRAIN_W-1:0]   ntrain_q, ntrain_d;
  logic [TIME_W-1:0]    ntime_q, ntime_d;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  slot_t                ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  slot_t                ram_rdata;

  logic [PIDX_W-1:0]    plat_in;
  logic                 plat_ok;
  logic                 time_ok;
  logic [CNT_W-1:0]     cnt_sel;

  // Slot storage for all platforms
  sdt_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Decode the incoming request
  assign plat_in = PIDX_W'(platform_i);
  assign plat_ok = int'(platform_i) < PLATFORMS;
  assign time_ok = (time_of_day_i != '0) && (time_of_day_i < TIME_NONE);
  assign cnt_sel = plat_ok ? cnt_mem_q[plat_in] : '0;

  // Sequencer: upward scan for queries, downward shift for inserts
  always_comb begin
    state_d   = state_q;
    plat_d    = plat_q;
    time_d    = time_q;
    train_d   = train_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    cnt_we    = 1'b0;
    done_d    = 1'b0;
    status_d  = ST_OK;
    found_d   = 1'b0;
    ntrain_d  = '0;
    ntime_d   = TIME_NONE;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        // Prefetch the first slot the scan will need
        if (cmd_i == CMD_QUERY) begin
          ram_raddr = slot_addr(plat_in, '0);
        end else begin
          ram_raddr = slot_addr(plat_in, CNT_W'(cnt_sel - 1'b1));
        end
        if (start) begin
          plat_d  = plat_in;
          time_d  = time_of_day_i;
          train_d = train_number_i;
          cnt_d   = cnt_sel;
          pos_d   = (cmd_i == CMD_QUERY) ? '0 : cnt_sel;
          priority if (!plat_ok) begin
            done_d   = 1'b1;
            status_d = ST_BAD_PLAT;
          end else if (!time_ok) begin
            done_d   = 1'b1;
            status_d = ST_BAD_TIME;
          end else if (cmd_i == CMD_QUERY) begin
            if (cnt_sel == '0) begin
              done_d = 1'b1;
            end else begin
              state_d = S_QSCAN;
            end
          end else if (cnt_sel >= CNT_W'(ENTRIES)) begin
            done_d   = 1'b1;
            status_d = ST_FULL;
          end else begin
            state_d = S_ISCAN;
          end
        end
      end

      S_QSCAN: begin
        // ram_rdata holds slot pos_q; fetch the next one
        ram_raddr = slot_addr(plat_q, CNT_W'(pos_q + 1'b1));
        priority if (ram_rdata.tod > time_q) begin
          done_d   = 1'b1;
          found_d  = 1'b1;
          ntrain_d = ram_rdata.train;
          ntime_d  = ram_rdata.tod;
          state_d  = S_IDLE;
        end else if (CNT_W'(pos_q + 1'b1) == cnt_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          pos_d = CNT_W'(pos_q + 1'b1);
        end
      end

      S_ISCAN: begin
        // ram_rdata holds slot pos_q-1; shift it up or drop the new entry in
        ram_raddr = slot_addr(plat_q, CNT_W'(pos_q - 2'd2));
        ram_we    = 1'b1;
        ram_waddr = slot_addr(plat_q, pos_q);
        if (pos_q != '0 && ram_rdata.tod > time_q) begin
          ram_wdata = ram_rdata;
          pos_d     = CNT_W'(pos_q - 1'b1);
        end else begin
          ram_wdata.tod   = time_q;
          ram_wdata.train = train_q;
          cnt_we          = 1'b1;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state, counts and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      plat_q   <= '0;
      time_q   <= '0;
      train_q  <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
      status_q <= ST_OK;
      found_q  <= 1'b0;
      ntrain_q <= '0;
      ntime_q  <= TIME_NONE;
      for (int p = 0; p < PLATFORMS; p++) begin
        cnt_mem_q[p] <= '0;
      end
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      plat_q   <= plat_d;
      time_q   <= time_d;
      train_q  <= train_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
      found_q  <= found_d;
      ntrain_q <= ntrain_d;
      ntime_q  <= ntime_d;
      if (cnt_we) begin
        cnt_mem_q[plat_q] <= CNT_W'(cnt_q + 1'b1);
      end
    end
  end

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign found_o      = found_q & done_q;
  assign next_train_o = ntrain_q;
  assign next_time_o  = ntime_q;

  // Checks
  `SDT_ASSERT_IMP(a_found_ok, found_o,
    done_o && status_o == ST_OK && next_time_o != TIME_NONE,
    "found result without ok status or with empty time")
  `SDT_ASSERT_IMP(a_err_quiet, done_o && status_o != ST_OK,
    !found_o && next_train_o == '0 && next_time_o == TIME_NONE,
    "error result carries departure data")
  `SDT_ASSERT_IMP(a_done_origin, done_o, $past(start) || $past(busy),
    "result strobe without a request in progress")
  `SDT_ASSERT_IMP(a_ins_bound, state_q == S_ISCAN,
    pos_q <= cnt_q && cnt_q < CNT_W'(ENTRIES),
    "insert shift beyond the table fill")
  `SDT_ASSERT_NXT(a_ins_done, state_q == S_ISCAN && state_d == S_IDLE,
    done_o && status_o == ST_OK && !found_o,
    "insert finished without an ok result")

endmodule
